// ===== design/assert_macros.svh =====
// Assertion helpers. Each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sha256c_pkg.sv =====
package sha256c_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned SCHED_DEPTH = 16;
    localparam int unsigned CHAIN_DEPTH = 8;

    // control strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;     // word accepted
        logic init;     // copy chain into working vars
        logic advance;  // produce next schedule word, rotate store
        logic rnd;      // one compression round
        logic emit;     // form one digest word, rotate chain/working vars
    } sha256c_ctrl_t;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== design/sha256c_sched.sv =====
// Message schedule: 16-word rotating store with fixed taps, W+K registered.
module sha256c_sched
    import sha256c_pkg::*;
(
    input  logic                clk,
    input  sha256c_ctrl_t       ctrl,
    input  logic [3:0]          wr_index,
    input  logic [31:0]         wr_data,
    input  logic [5:0]          round_next,
    output logic [31:0]         wk
);

    logic [31:0] sched_reg  [SCHED_DEPTH];
    logic [31:0] sched_next [SCHED_DEPTH];
    logic [31:0] wk_reg;
    logic [31:0] wk_next;
    logic [31:0] w_new;

    // sched_reg[i] holds schedule position (t + i) mod 16 for round t
    always_comb
    begin
        if (round_next[5:4] == 2'd0)
        begin
            w_new = sched_reg[0];
        end
        else
        begin
            w_new = small_sigma1(sched_reg[14]) + sched_reg[9]
                  + small_sigma0(sched_reg[1]) + sched_reg[0];
        end
    end

    always_comb
    begin
        sched_next = sched_reg;
        wk_next    = wk_reg;
        if (ctrl.load)
        begin
            sched_next[wr_index] = wr_data;
        end
        if (ctrl.advance)
        begin
            for (int i = 0; i < SCHED_DEPTH - 1; i++)
            begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[SCHED_DEPTH - 1] = w_new;
            wk_next = w_new + ROUND_K[round_next];
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        wk_reg    <= wk_next;
    end

    assign wk = wk_reg;

endmodule

// ===== design/sha256c_round.sv =====
// Chaining store, working variables a..h and the shared round unit.
module sha256c_round
    import sha256c_pkg::*;
(
    input  logic                clk,
    input  sha256c_ctrl_t       ctrl,
    input  logic [3:0]          wr_index,
    input  logic [31:0]         wr_chain,
    input  logic [31:0]         wk,
    output logic [31:0]         digest
);

    logic [31:0] chain_reg  [CHAIN_DEPTH];
    logic [31:0] chain_next [CHAIN_DEPTH];
    logic [31:0] work_reg   [CHAIN_DEPTH];
    logic [31:0] work_next  [CHAIN_DEPTH];
    logic [31:0] digest_reg;
    logic [31:0] digest_next;
    logic [31:0] t1;
    logic [31:0] t2;

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + choose(work_reg[4], work_reg[5], work_reg[6]) + wk;
    assign t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);

    always_comb
    begin
        chain_next  = chain_reg;
        work_next   = work_reg;
        digest_next = digest_reg;
        if (ctrl.load && !wr_index[3])
        begin
            chain_next[wr_index[2:0]] = wr_chain;
        end
        if (ctrl.init)
        begin
            work_next = chain_reg;
        end
        if (ctrl.rnd)
        begin
            work_next[0] = t1 + t2;
            work_next[1] = work_reg[0];
            work_next[2] = work_reg[1];
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3] + t1;
            work_next[5] = work_reg[4];
            work_next[6] = work_reg[5];
            work_next[7] = work_reg[6];
        end
        // eight rotations bring the chain back into place
        if (ctrl.emit)
        begin
            digest_next = chain_reg[0] + work_reg[0];
            for (int i = 0; i < CHAIN_DEPTH - 1; i++)
            begin
                chain_next[i] = chain_reg[i + 1];
                work_next[i]  = work_reg[i + 1];
            end
            chain_next[CHAIN_DEPTH - 1] = chain_reg[0];
            work_next[CHAIN_DEPTH - 1]  = work_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg  <= chain_next;
        work_reg   <= work_next;
        digest_reg <= digest_next;
    end

    assign digest = digest_reg;

endmodule

// ===== design/sha256_block_compression.sv =====
// Word at index 0..14: stored, busy stays low, no result.
// Word at index 15: busy through a setup state, 64 rounds at one per cycle
// through the shared round unit and an output phase; digest words 0..7 appear
// on consecutive cycles, registered from the output phase.
// The receiver cannot stall.
// rst_n (async, active low) clears sequencer and strobe; stores are not reset.
`include "assert_macros.svh"

module sha256_block_compression
    import sha256c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  word_index,
    input  logic [31:0] message_word,
    input  logic [31:0] chain_word,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        last_word
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [5:0] LAST_ROUND = 6'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_OUT   = 3'(CHAIN_DEPTH - 1);
    localparam logic [3:0] LAST_INDEX = 4'(SCHED_DEPTH - 1);

    logic [1:0]     state_reg, state_next;
    logic [5:0]     cnt_reg, cnt_next;      // round count, then output count
    logic           valid_reg, valid_next;
    logic [2:0]     index_reg, index_next;
    logic           last_reg, last_next;
    logic           accept;
    logic [5:0]     round_next;
    logic [31:0]    wk_word;
    sha256c_ctrl_t  ctrl;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = 1'b0;
        index_next = index_reg;
        last_next  = 1'b0;
        round_next = 6'd0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = start;
                if (start && (word_index == LAST_INDEX))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // W0 + K0 staged ahead of round 0
                ctrl.init    = 1'b1;
                ctrl.advance = 1'b1;
                round_next   = 6'd0;
                cnt_next     = 6'd0;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctrl.rnd   = 1'b1;
                round_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_ROUND)
                begin
                    cnt_next   = 6'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                    cnt_next     = cnt_reg + 6'd1;
                end
            end
            ST_OUT:
            begin
                ctrl.emit  = 1'b1;
                valid_next = 1'b1;
                index_next = cnt_reg[2:0];
                last_next  = (cnt_reg[2:0] == LAST_OUT);
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == LAST_OUT)
                begin
                    cnt_next   = 6'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
            valid_reg <= 1'b0;
            index_reg <= 3'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            index_reg <= index_next;
            last_reg  <= last_next;
        end
    end

    sha256c_sched u_sched (
        .clk        (clk),
        .ctrl       (ctrl),
        .wr_index   (word_index),
        .wr_data    (message_word),
        .round_next (round_next),
        .wk         (wk_word)
    );

    sha256c_round u_round (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_index (word_index),
        .wr_chain (chain_word),
        .wk       (wk_word),
        .digest   (digest_word)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign digest_valid = valid_reg;
    assign digest_index = index_reg;
    assign last_word    = last_reg;

    `ASSERT_NEXT(a_start_rounds, accept && (word_index == LAST_INDEX), state_reg == ST_INIT, "index 15 word did not start the rounds")
    `ASSERT_NEXT(a_rounds_done, (state_reg == ST_ROUND) && (cnt_reg == LAST_ROUND), (state_reg == ST_OUT) && (cnt_reg == 6'd0), "round phase did not end after 64 rounds")
    `ASSERT_NEXT(a_last_out, (state_reg == ST_OUT) && (cnt_reg[2:0] == LAST_OUT), (state_reg == ST_IDLE) && digest_valid && last_word && (digest_index == LAST_OUT), "last digest word not marked")
    `ASSERT_IMPL(a_valid_src, digest_valid, $past(state_reg) == ST_OUT, "digest word outside output phase")

endmodule

// ===== verif/sha256_block_compression_checker.sv =====
`timescale 1ns / 100ps

module sha256_block_compression_checker
    import sha256c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  word_index,
    input  logic [31:0] message_word,
    input  logic [31:0] chain_word,
    input  logic        digest_valid,
    input  logic [31:0] digest_word,
    input  logic [2:0]  digest_index,
    input  logic        last_word,
    output int          errors,
    output int          pending
);

    localparam logic [3:0] FINAL_POS = 4'd15;
    localparam int REPORT_LIMIT = 10;

    localparam logic [31:0] RC [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } exp_word_t;

    logic [31:0] msg_sched [SCHED_DEPTH];
    logic [31:0] chain_val [CHAIN_DEPTH];
    exp_word_t   digest_q [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    // 64 rounds; schedule is expanded in place, so the store keeps words 48..63
    task automatic compress_and_queue();
        logic [31:0] v [8];
        logic [31:0] w2, w15, t1, t2, wt;
        for (int i = 0; i < 8; i++)
            v[i] = chain_val[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                w2  = msg_sched[(r - 2) & 15];
                w15 = msg_sched[(r - 15) & 15];
                msg_sched[r & 15] = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10))
                                  + msg_sched[(r - 7) & 15]
                                  + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                                  + msg_sched[r & 15];
            end
            wt = msg_sched[r & 15];
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[r] + wt;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            digest_q.push_back('{word: chain_val[k] + v[k], index: k[2:0], last: (k == 7)});
    endtask

    always @(posedge clk)
    begin
        exp_word_t exp_d;
        if (rst_n)
        begin
            if (digest_valid)
            begin
                if (digest_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected digest word %h idx %0d last %0b",
                                 $time, digest_word, digest_index, last_word);
                end
                else
                begin
                    exp_d = digest_q.pop_front();
                    if (digest_word !== exp_d.word || digest_index !== exp_d.index ||
                        last_word !== exp_d.last)
                    begin
                        errors = errors + 1;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                                     $time, exp_d.word, exp_d.index, exp_d.last,
                                     digest_word, digest_index, last_word);
                    end
                end
            end
            // word accepted: update predictor, position 15 kicks off a block
            if (start && !busy)
            begin
                msg_sched[word_index] = message_word;
                if (word_index < CHAIN_DEPTH)
                    chain_val[word_index] = chain_word;
                if (word_index == FINAL_POS)
                    compress_and_queue();
            end
            pending = digest_q.size();
        end
    end

endmodule

// ===== verif/sha256_block_compression_test.sv =====
`timescale 1ns / 100ps

module sha256_block_compression_test;

    localparam logic [3:0] FINAL_POS = 4'd15;  // position that launches the rounds
    localparam int RANDOM_WORDS = 160;
    localparam int DRAIN_LIMIT = 2000;         // cycles allowed for the tail to empty
    localparam int TAIL_CYCLES = 80;           // longer than the digest latency

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  word_index;
    logic [31:0] message_word;
    logic [31:0] chain_word;
    logic        digest_valid;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_word;

    int errors;
    int pending;      // digest words still owed by the block
    int sent;         // words accepted so far
    int idle_pct;     // chance per cycle that the sender holds off
    bit drained_mid;

    sha256_block_compression dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .word_index   (word_index),
        .message_word (message_word),
        .chain_word   (chain_word),
        .digest_valid (digest_valid),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .last_word    (last_word)
    );

    sha256_block_compression_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .word_index   (word_index),
        .message_word (message_word),
        .chain_word   (chain_word),
        .digest_valid (digest_valid),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .last_word    (last_word),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: reports failure and ends the run if it is still going at its timeout.
    initial
    begin
        #2000000;
        $display("sha256_block_compression_test failed");
        $finish;
    end

    // Biased toward all-zero / all-one words so carries and rotations hit the edges.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Idle phases by progress: none, 47%, 35%, none, then around again.
    function automatic int phase_idle(input int n);
        case ((n / 40) % 4)
            1: return 47;
            2: return 35;
            default: return 0;
        endcase
    endfunction

    // Present one word and hold it until the block takes it (start high, busy low).
    // start stays high after acceptance so back-to-back words need one assignment.
    task automatic send_word(input logic [3:0] idx, input logic [31:0] msg,
                             input logic [31:0] chn);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        word_index   <= idx;
        message_word <= msg;
        chain_word   <= chn;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // Sender goes quiet until every digest word owed has come out.
    // It first waits on the clock so the checker has seen the last acceptance.
    task automatic wait_for_digests();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Well-formed block: positions 0..14 in order or shuffled, then 15.
    task automatic send_block(input bit shuffle);
        int order [15];
        int j;
        int tmp;
        for (int i = 0; i < 15; i++)
            order[i] = i;
        if (shuffle)
        begin
            for (int i = 14; i > 0; i--)
            begin
                j = $urandom_range(i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        for (int i = 0; i < 15; i++)
            send_word(order[i][3:0], pick_word(), pick_word());
        send_word(FINAL_POS, pick_word(), pick_word());
    endtask

    initial
    begin
        int n;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        word_index   <= '0;
        message_word <= '0;
        chain_word   <= '0;
        sent         = 0;
        idle_pct     = 0;
        drained_mid  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // First block writes every position, so no store entry is ever read unwritten.
        // Message zeros under an all-ones chain, then all-ones message at 8..14,
        // zero message at 15; the chain words at 8..15 are ignored.
        for (int i = 0; i < 8; i++)
            send_word(i[3:0], 32'h0000_0000, 32'hffff_ffff);
        for (int i = 8; i < 15; i++)
            send_word(i[3:0], 32'hffff_ffff, 32'h0000_0000);
        send_word(FINAL_POS, 32'h0000_0000, 32'hffff_ffff);
        // Partial reload: position 4 written twice (second write wins), chain
        // word at 11 must be ignored, the rest runs on the expanded leftovers
        // of the previous block and the persisting chain.
        send_word(4'd4, 32'hffff_ffff, 32'h0000_0000);
        send_word(4'd4, 32'h1234_5678, 32'h89ab_cdef);
        send_word(4'd11, 32'h8000_0001, 32'hffff_ffff);
        send_word(FINAL_POS, 32'hffff_ffff, 32'h0000_0000);
        // Lone position 15: a block launched straight from the leftover state.
        send_word(FINAL_POS, 32'h5a5a_a5a5, 32'ha5a5_5a5a);
        wait_for_digests();

        // --- random ---
        // Mostly full blocks with random content; some short bursts at random
        // positions, which may launch a block early or partially overwrite one.
        while (sent < 21 + RANDOM_WORDS)
        begin
            idle_pct = phase_idle(sent);
            if ($urandom_range(99) < 75)
                send_block(1'($urandom_range(1)));
            else
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    send_word(4'($urandom_range(15)), pick_word(), pick_word());
            end
            if (!drained_mid && sent > 100)
            begin
                drained_mid = 1'b1;
                wait_for_digests();
            end
        end

        // --- wind-down ---
        start <= 1'b0;
        n = 0;
        @(posedge clk);
        while (pending != 0 && n < DRAIN_LIMIT)
        begin
            n++;
            @(posedge clk);
        end
        if (pending != 0)
        begin
            $display("sha256_block_compression_test failed");
            $finish;
        end
        else
        begin
            // let any stray digest words show up before judging
            repeat (TAIL_CYCLES) @(posedge clk);
            if (errors == 0 && pending == 0)
                $display("sha256_block_compression_test passed");
            else
                $display("sha256_block_compression_test failed");
            $finish;
        end
    end

endmodule

// ===== sha256_block_compression.f =====
+incdir+design
design/sha256c_pkg.sv
design/sha256c_sched.sv
design/sha256c_round.sv
design/sha256_block_compression.sv
verif/sha256_block_compression_checker.sv
verif/sha256_block_compression_test.sv
